// File: hw/rtl/ipac_pkg.sv
// ipac_pkg: shared types and constants for the IP address classifier.
// No dependencies; used by ipac_classify and ip_address_classifier_top.
package ipac_pkg;

    // Address family codes
    localparam logic [1:0] FAM_NONE = 2'd0;
    localparam logic [1:0] FAM_V4   = 2'd1;
    localparam logic [1:0] FAM_V6   = 2'd2;

    // IPv4 prefixes (value / mask pairs)
    localparam logic [31:0] V4_NET10_VAL   = 32'h0A00_0000;
    localparam logic [31:0] V4_NET10_MSK   = 32'hFF00_0000;
    localparam logic [31:0] V4_NET172_VAL  = 32'hAC10_0000;
    localparam logic [31:0] V4_NET172_MSK  = 32'hFFF0_0000;
    localparam logic [31:0] V4_NET192_VAL  = 32'hC0A8_0000;
    localparam logic [31:0] V4_NET192_MSK  = 32'hFFFF_0000;
    localparam logic [31:0] V4_CGNAT_VAL   = 32'h6440_0000;
    localparam logic [31:0] V4_CGNAT_MSK   = 32'hFFC0_0000;
    localparam logic [31:0] V4_LLOCAL_VAL  = 32'hA9FE_0000;
    localparam logic [31:0] V4_LLOCAL_MSK  = 32'hFFFF_0000;
    localparam logic [31:0] V4_THIS_VAL    = 32'h0000_0000;
    localparam logic [31:0] V4_LOOP_VAL    = 32'h7F00_0000;
    localparam logic [31:0] V4_OCT_MSK     = 32'hFF00_0000;
    localparam logic [31:0] V4_IETF_VAL    = 32'hC000_0000;
    localparam logic [31:0] V4_TEST1_VAL   = 32'hC000_0200;
    localparam logic [31:0] V4_TEST2_VAL   = 32'hC633_6400;
    localparam logic [31:0] V4_TEST3_VAL   = 32'hCB00_7100;
    localparam logic [31:0] V4_NET24_MSK   = 32'hFFFF_FF00;
    localparam logic [31:0] V4_BENCH_VAL   = 32'hC612_0000;
    localparam logic [31:0] V4_BENCH_MSK   = 32'hFFFE_0000;
    localparam logic [31:0] V4_MCAST_VAL   = 32'hE000_0000;
    localparam logic [31:0] V4_RSVD_VAL    = 32'hF000_0000;
    localparam logic [31:0] V4_NIB_MSK     = 32'hF000_0000;

    // IPv6 prefixes
    localparam logic [9:0]  V6_LLOCAL_P10  = 10'h3FA;
    localparam logic [9:0]  V6_SLOCAL_P10  = 10'h3FB;
    localparam logic [7:0]  V6_ULA_P8      = 8'hFC;
    localparam logic [7:0]  V6_ULA_MSK8    = 8'hFE;
    localparam logic [7:0]  V6_MCAST_P8    = 8'hFF;
    localparam logic [63:0] V6_DISCARD_HI  = 64'h0100_0000_0000_0000;
    localparam logic [31:0] V6_DOC_P32     = 32'h2001_0DB8;
    localparam logic [19:0] V6_DOC2_P20    = 20'h3FFF0;
    localparam logic [31:0] V6_TEREDO_P32  = 32'h2001_0000;
    localparam logic [15:0] V6_6TO4_P16    = 16'h2002;
    localparam logic [31:0] V6_MAPPED_MID  = 32'h0000_FFFF;

    typedef struct packed {
        logic unspecified;
        logic loopback;
        logic multicast;
        logic link_local;
        logic private_v4;
        logic unique_local;
        logic special_purpose;
        logic teredo;
        logic six_to_four;
        logic needs_zone;
        logic unicast_target;
        logic announceable;
    } t_flags;

endpackage

// File: hw/rtl/ip_address_classifier_top.sv
// ip_address_classifier_top: IPv4/IPv6 special-purpose address classifier.
// An accepted input word passes the input register, then the result register, to result valid.
// Throughput: one word per cycle; the input register and result register
// each advance whenever the stage after them is empty or being drained.
// Reset (synchronous, active low) empties both stages; no other state.
// Depends on ipac_pkg and ipac_classify.
module ip_address_classifier_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input word channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_addr_family,
    input  logic [63:0] i_addr_hi,
    input  logic [63:0] i_addr_lo,
    input  logic [31:0] i_scope_index,
    // result word channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_is_unspecified,
    output logic        o_is_loopback,
    output logic        o_is_multicast,
    output logic        o_is_link_local,
    output logic        o_is_private_v4,
    output logic        o_is_unique_local,
    output logic        o_is_special_purpose,
    output logic        o_is_teredo,
    output logic        o_is_six_to_four,
    output logic        o_needs_zone,
    output logic        o_is_unicast_target,
    output logic        o_is_announceable
);
    import ipac_pkg::*;

    // Stage 1: registered input word
    logic        r_in_valid, n_in_valid;
    logic [1:0]  r_family;
    logic [63:0] r_hi;
    logic [63:0] r_lo;
    logic [31:0] r_scope;

    // Stage 2: registered result word
    logic        r_out_valid, n_out_valid;
    t_flags      r_flags;
    t_flags      flags;

    logic        in_fire;   // input word taken this cycle
    logic        s2_ready;  // result register can take a word
    logic        s2_load;   // stage 1 moves into the result register

    // Result register frees up when empty or when its word leaves.
    assign s2_ready   = !r_out_valid || i_out_ready;
    // Input register frees up when empty or when its word moves on.
    assign o_in_ready = !r_in_valid || s2_ready;
    assign in_fire    = i_in_valid && o_in_ready;
    assign s2_load    = r_in_valid && s2_ready;

    ipac_classify u_classify (
        .i_addr_family (r_family),
        .i_addr_hi     (r_hi),
        .i_addr_lo     (r_lo),
        .i_scope_index (r_scope),
        .o_flags       (flags)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (o_in_ready) begin
            n_in_valid = i_in_valid;
        end
        n_out_valid = r_out_valid;
        if (s2_ready) begin
            n_out_valid = r_in_valid;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_family <= i_addr_family;
            r_hi     <= i_addr_hi;
            r_lo     <= i_addr_lo;
            r_scope  <= i_scope_index;
        end
        if (s2_load) begin
            r_flags <= flags;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_is_unspecified     = r_flags.unspecified;
    assign o_is_loopback        = r_flags.loopback;
    assign o_is_multicast       = r_flags.multicast;
    assign o_is_link_local      = r_flags.link_local;
    assign o_is_private_v4      = r_flags.private_v4;
    assign o_is_unique_local    = r_flags.unique_local;
    assign o_is_special_purpose = r_flags.special_purpose;
    assign o_is_teredo          = r_flags.teredo;
    assign o_is_six_to_four     = r_flags.six_to_four;
    assign o_needs_zone         = r_flags.needs_zone;
    assign o_is_unicast_target  = r_flags.unicast_target;
    assign o_is_announceable    = r_flags.announceable;

endmodule

// File: hw/rtl/ipac_classify.sv
// ipac_classify: prefix-match logic producing the twelve address flags.
// Depends on ipac_pkg (family codes, prefix constants, t_flags).
module ipac_classify (
    input  logic [1:0]      i_addr_family,
    input  logic [63:0]     i_addr_hi,
    input  logic [63:0]     i_addr_lo,
    input  logic [31:0]     i_scope_index,
    output ipac_pkg::t_flags o_flags
);
    import ipac_pkg::*;

    logic        is_set, raw6, mapped, eff4;
    logic [31:0] ip;
    logic        v4_priv, v4_spec;
    logic        v6_ll, v6_sl, v6_ula, v6_unspec, v6_loop;
    logic        unspec, loop, mcast, ll, priv4, special, nz;

    assign is_set = (i_addr_family == FAM_V4) || (i_addr_family == FAM_V6);
    assign raw6   = (i_addr_family == FAM_V6);
    assign mapped = raw6 && (i_addr_hi == '0) && (i_addr_lo[63:32] == V6_MAPPED_MID);
    assign eff4   = (i_addr_family == FAM_V4) || mapped;
    assign ip     = i_addr_lo[31:0];

    assign v4_priv = ((ip & V4_NET10_MSK)  == V4_NET10_VAL)  ||
                     ((ip & V4_NET172_MSK) == V4_NET172_VAL) ||
                     ((ip & V4_NET192_MSK) == V4_NET192_VAL) ||
                     ((ip & V4_CGNAT_MSK)  == V4_CGNAT_VAL)  ||
                     ((ip & V4_LLOCAL_MSK) == V4_LLOCAL_VAL);

    assign v4_spec = v4_priv ||
                     ((ip & V4_OCT_MSK)   == V4_THIS_VAL)  ||
                     ((ip & V4_OCT_MSK)   == V4_LOOP_VAL)  ||
                     ((ip & V4_NET24_MSK) == V4_IETF_VAL)  ||
                     ((ip & V4_NET24_MSK) == V4_TEST1_VAL) ||
                     ((ip & V4_BENCH_MSK) == V4_BENCH_VAL) ||
                     ((ip & V4_NET24_MSK) == V4_TEST2_VAL) ||
                     ((ip & V4_NET24_MSK) == V4_TEST3_VAL) ||
                     ((ip & V4_NIB_MSK)   == V4_RSVD_VAL);

    assign v6_ll     = (i_addr_hi[63:54] == V6_LLOCAL_P10);
    assign v6_sl     = (i_addr_hi[63:54] == V6_SLOCAL_P10);
    assign v6_ula    = ((i_addr_hi[63:56] & V6_ULA_MSK8) == V6_ULA_P8);
    assign v6_unspec = (i_addr_hi == '0) && (i_addr_lo == '0);
    assign v6_loop   = (i_addr_hi == '0) && (i_addr_lo == 64'd1);

    always_comb begin
        if (eff4) begin
            unspec  = (ip == '0);
            loop    = ((ip & V4_OCT_MSK) == V4_LOOP_VAL);
            mcast   = ((ip & V4_NIB_MSK) == V4_MCAST_VAL);
            ll      = ((ip & V4_LLOCAL_MSK) == V4_LLOCAL_VAL);
            priv4   = v4_priv;
            special = v4_spec;
        end else begin
            unspec  = v6_unspec;
            loop    = v6_loop;
            mcast   = (i_addr_hi[63:56] == V6_MCAST_P8);
            ll      = v6_ll;
            priv4   = 1'b0;
            special = v6_unspec || v6_loop || v6_ula || v6_ll || v6_sl ||
                      (i_addr_hi == V6_DISCARD_HI) ||
                      (i_addr_hi[63:32] == V6_DOC_P32) ||
                      (i_addr_hi[63:44] == V6_DOC2_P20);
        end
    end

    assign nz = raw6 && v6_ll && (i_scope_index == '0);

    // An empty or undefined family forces every flag low.
    always_comb begin
        o_flags.unspecified     = is_set && unspec;
        o_flags.loopback        = is_set && loop;
        o_flags.multicast       = is_set && mcast;
        o_flags.link_local      = is_set && ll;
        o_flags.private_v4      = is_set && priv4;
        o_flags.unique_local    = raw6 && v6_ula;
        o_flags.special_purpose = is_set && special;
        o_flags.teredo          = raw6 && (i_addr_hi[63:32] == V6_TEREDO_P32);
        o_flags.six_to_four     = raw6 && (i_addr_hi[63:48] == V6_6TO4_P16);
        o_flags.needs_zone      = nz;
        o_flags.unicast_target  = is_set && !unspec && !mcast && !nz;
        o_flags.announceable    = is_set && !unspec && !loop && !mcast && !ll;
    end

endmodule

// File: hw/rtl/ipac_checker.sv
// ipac_checker: port-level assertions for ip_address_classifier_top.
// Bound to the top level by the bind statement at the end of this file.
module ipac_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_is_unspecified,
    input logic        o_is_loopback,
    input logic        o_is_multicast,
    input logic        o_is_link_local,
    input logic        o_is_unique_local,
    input logic        o_is_teredo,
    input logic        o_is_six_to_four,
    input logic        o_needs_zone,
    input logic        o_is_unicast_target,
    input logic        o_is_announceable
);

    // A result word waiting on the sink stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped while stalled");

    // Reset empties the result stage.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A zoneless link-local word is never a usable unicast target.
    a_zone_unicast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_needs_zone |-> o_is_link_local && !o_is_unicast_target)
        else $error("zoneless link-local flagged as unicast target");

    // Announceable excludes loopback, link-local, multicast and unspecified.
    a_announce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_announceable |->
            !o_is_loopback && !o_is_link_local && !o_is_multicast &&
            !o_is_unspecified && o_is_unicast_target)
        else $error("announceable flag inconsistent");

    // The raw IPv6 prefix tests are mutually exclusive.
    a_raw_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0({o_is_teredo, o_is_six_to_four, o_is_unique_local}))
        else $error("raw IPv6 prefix flags overlap");

endmodule

bind ip_address_classifier_top ipac_checker u_ipac_checker (.*);
